FILE: design/csg_pkg.sv
// Shared types and codes for the CSG span combiner.
// No dependencies; used by csg_span_core and csg_span_combine.
package csg_pkg;

    localparam int RANGE_BITS = 32;

    typedef logic [RANGE_BITS-1:0] range_t;

    localparam range_t RANGE_INF = '1;

    typedef enum logic [1:0] {
        OP_UNION     = 2'd0,
        OP_INTERSECT = 2'd1,
        OP_SUBTRACT  = 2'd2,
        OP_UNUSED    = 2'd3
    } combine_op_t;

    typedef enum logic [1:0] {
        SRC_A    = 2'd0,
        SRC_B    = 2'd1,
        SRC_NONE = 2'd2,
        SRC_RSVD = 2'd3
    } base_src_t;

    typedef enum logic [1:0] {
        NRM_A_ENTRY = 2'd0,
        NRM_A_EXIT  = 2'd1,
        NRM_B_ENTRY = 2'd2,
        NRM_B_EXIT  = 2'd3
    } normal_src_t;

    typedef struct packed {
        logic   a_hit;
        range_t a_entry;
        range_t a_exit;
        logic   b_hit;
        range_t b_entry;
        range_t b_exit;
        range_t far_limit;
    } span_item_t;

    typedef struct packed {
        logic        hit;
        range_t      entry_range;
        range_t      exit_range;
        base_src_t   base_source;
        normal_src_t entry_normal_source;
        logic        entry_normal_negated;
        normal_src_t exit_normal_source;
        logic        exit_normal_negated;
        logic        occluded;
    } span_result_t;

endpackage

FILE: design/csg_span_combine.sv
// Top level of the CSG span combiner: input register, combine logic, result register.
// Depends on csg_pkg and csg_span_core.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one ray item: the hit flags and
//   entry/exit distances of both child solids plus the occlusion limit.
//   Output channel (out_valid / out_stall) carries one result item per input
//   item, in order.
//   cfg_wr_en / cfg_wr_data write the combine operation; write it only while
//   no item is in flight.
// Timing: an accepted item is loaded into the input register; its result then
//   passes through the combine logic into the result register, which drives the
//   output until the receiver takes it.
// Throughput: one item per cycle while the output is not stalled; the combine
//   logic is a single pass of 32-bit compares and selects between the two registers.
// Reset: both stages empty, operation set to union.
// Stall: when out_stall holds the result register, an empty input register still
//   fills, so at most one further item is taken before in_stall rises; nothing is
//   dropped or repeated.
module csg_span_combine
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [1:0]                cfg_wr_data,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic                      a_hit,
    input  logic [csg_pkg::RANGE_BITS-1:0] a_entry,
    input  logic [csg_pkg::RANGE_BITS-1:0] a_exit,
    input  logic                      b_hit,
    input  logic [csg_pkg::RANGE_BITS-1:0] b_entry,
    input  logic [csg_pkg::RANGE_BITS-1:0] b_exit,
    input  logic [csg_pkg::RANGE_BITS-1:0] far_limit,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic                      hit,
    output logic [csg_pkg::RANGE_BITS-1:0] entry_range,
    output logic [csg_pkg::RANGE_BITS-1:0] exit_range,
    output logic [1:0]                base_source,
    output logic [1:0]                entry_normal_source,
    output logic                      entry_normal_negated,
    output logic [1:0]                exit_normal_source,
    output logic                      exit_normal_negated,
    output logic                      occluded
);

    csg_pkg::combine_op_t  combine_op_reg;
    csg_pkg::span_item_t   item_reg;
    logic                  item_valid_reg;
    csg_pkg::span_result_t result_reg;
    logic                  out_valid_reg;
    csg_pkg::span_result_t result_next;
    logic                  out_ready;
    logic                  item_ready;

    assign out_ready  = !out_valid_reg || !out_stall;
    assign item_ready = !item_valid_reg || out_ready;
    assign in_stall   = !item_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            combine_op_reg <= csg_pkg::OP_UNION;
        else if (cfg_wr_en)
            combine_op_reg <= csg_pkg::combine_op_t'(cfg_wr_data);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (item_ready)
                item_valid_reg <= in_valid;
            if (out_ready)
                out_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_ready && in_valid)
        begin
            item_reg.a_hit     <= a_hit;
            item_reg.a_entry   <= a_entry;
            item_reg.a_exit    <= a_exit;
            item_reg.b_hit     <= b_hit;
            item_reg.b_entry   <= b_entry;
            item_reg.b_exit    <= b_exit;
            item_reg.far_limit <= far_limit;
        end
        if (out_ready && item_valid_reg)
            result_reg <= result_next;
    end

    csg_span_core u_core
    (
        .combine_op (combine_op_reg),
        .item       (item_reg),
        .result     (result_next)
    );

    assign out_valid            = out_valid_reg;
    assign hit                  = result_reg.hit;
    assign entry_range          = result_reg.entry_range;
    assign exit_range           = result_reg.exit_range;
    assign base_source          = result_reg.base_source;
    assign entry_normal_source  = result_reg.entry_normal_source;
    assign entry_normal_negated = result_reg.entry_normal_negated;
    assign exit_normal_source   = result_reg.exit_normal_source;
    assign exit_normal_negated  = result_reg.exit_normal_negated;
    assign occluded             = result_reg.occluded;

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> item_valid_reg)
        else $error("accepted item did not reach the input register");

    a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> item_valid_reg && out_valid_reg)
        else $error("input stalled with a free stage");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && out_valid_reg && out_stall |=> item_valid_reg && out_valid_reg)
        else $error("pipeline item lost during output stall");

    a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit |-> base_source == csg_pkg::SRC_NONE && entry_range == '0
                              && exit_range == '0)
        else $error("miss result carries span data");

endmodule

FILE: design/csg_span_core.sv
// Combinational span combination for one ray item.
// Depends on csg_pkg for item, result and code types.
module csg_span_core
(
    input  csg_pkg::combine_op_t  combine_op,
    input  csg_pkg::span_item_t   item,
    output csg_pkg::span_result_t result
);

    logic            ah;
    logic            bh;
    csg_pkg::range_t ae;
    csg_pkg::range_t ax;
    csg_pkg::range_t be;
    csg_pkg::range_t bx;
    csg_pkg::range_t far_lim;
    csg_pkg::span_result_t res;

    // A missed child has an infinite span
    assign ah      = item.a_hit;
    assign bh      = item.b_hit;
    assign ae      = ah ? item.a_entry : csg_pkg::RANGE_INF;
    assign ax      = ah ? item.a_exit  : csg_pkg::RANGE_INF;
    assign be      = bh ? item.b_entry : csg_pkg::RANGE_INF;
    assign bx      = bh ? item.b_exit  : csg_pkg::RANGE_INF;
    assign far_lim = item.far_limit;

    function automatic csg_pkg::span_result_t mk(
        input csg_pkg::base_src_t   base,
        input csg_pkg::range_t      en,
        input csg_pkg::range_t      ex,
        input csg_pkg::normal_src_t es,
        input logic                 eneg,
        input csg_pkg::normal_src_t xs,
        input logic                 xneg
    );
        csg_pkg::span_result_t r;
        r.hit                  = 1'b1;
        r.entry_range          = en;
        r.exit_range           = ex;
        r.base_source          = base;
        r.entry_normal_source  = es;
        r.entry_normal_negated = eneg;
        r.exit_normal_source   = xs;
        r.exit_normal_negated  = xneg;
        r.occluded             = 1'b0;
        return r;
    endfunction

    always_comb
    begin
        res.hit                  = 1'b0;
        res.entry_range          = '0;
        res.exit_range           = '0;
        res.base_source          = csg_pkg::SRC_NONE;
        res.entry_normal_source  = csg_pkg::NRM_A_ENTRY;
        res.entry_normal_negated = 1'b0;
        res.exit_normal_source   = csg_pkg::NRM_A_ENTRY;
        res.exit_normal_negated  = 1'b0;
        res.occluded             = 1'b0;

        case (combine_op)
            csg_pkg::OP_INTERSECT:
            begin
                if (ah && bh)
                begin
                    // normals follow the child whose entry lies in the other span
                    if (ae <= be && be <= ax)
                    begin
                        res = mk(csg_pkg::SRC_A, ae, bx, csg_pkg::NRM_B_ENTRY, 1'b0,
                                 csg_pkg::NRM_B_EXIT, 1'b0);
                        res.occluded = (ae < far_lim) && (ae != '0);
                    end
                    else if (be <= ae && ae <= bx)
                    begin
                        res = mk(csg_pkg::SRC_B, be, ax, csg_pkg::NRM_A_ENTRY, 1'b0,
                                 csg_pkg::NRM_A_EXIT, 1'b0);
                        res.occluded = (be < far_lim) && (be != '0);
                    end
                end
            end
            csg_pkg::OP_SUBTRACT:
            begin
                if (ah)
                begin
                    if (ax == '0 && bx == '0)
                    begin
                        if (be < ae)
                            res = mk(csg_pkg::SRC_B, be, ae, csg_pkg::NRM_B_ENTRY, 1'b1,
                                     csg_pkg::NRM_A_EXIT, 1'b0);
                        res.occluded = (be < ae) && (be < far_lim);
                    end
                    else if (ax == '0)
                    begin
                        if (bh && be < ae)
                            res = mk(csg_pkg::SRC_B, be, '0, csg_pkg::NRM_B_ENTRY, 1'b1,
                                     csg_pkg::NRM_B_EXIT, 1'b0);
                        else
                            res = mk(csg_pkg::SRC_A, ae, '0, csg_pkg::NRM_A_ENTRY, 1'b0,
                                     csg_pkg::NRM_A_EXIT, 1'b0);
                        res.occluded = 1'b1;
                    end
                    else if (bx == '0)
                    begin
                        if (ae < be)
                            res = mk(csg_pkg::SRC_B, be, ax, csg_pkg::NRM_B_ENTRY, 1'b1,
                                     csg_pkg::NRM_A_EXIT, 1'b0);
                        res.occluded = (be < far_lim);
                    end
                    else
                    begin
                        if (!bh)
                            res = mk(csg_pkg::SRC_A, ae, ax, csg_pkg::NRM_A_ENTRY, 1'b0,
                                     csg_pkg::NRM_A_EXIT, 1'b0);
                        else if (ae < be)
                            res = mk(csg_pkg::SRC_A, ae, be, csg_pkg::NRM_A_ENTRY, 1'b0,
                                     csg_pkg::NRM_B_ENTRY, 1'b1);
                        else if (bx < ax)
                            res = mk(csg_pkg::SRC_B, bx, ax, csg_pkg::NRM_B_EXIT, 1'b1,
                                     csg_pkg::NRM_A_EXIT, 1'b0);
                        else if (be >= ax || bx <= ae)
                            res = mk(csg_pkg::SRC_A, ae, ax, csg_pkg::NRM_A_ENTRY, 1'b0,
                                     csg_pkg::NRM_A_EXIT, 1'b0);

                        if (!bh || be >= ax || bx <= ae || ae < be)
                            res.occluded = (ae < far_lim) && (ae != '0);
                        else if (bx < ax)
                            res.occluded = (bx < far_lim) && (bx != '0);
                    end
                end
            end
            default:
            begin
                // union; the unused code behaves the same
                if (ah && bh)
                begin
                    if (be > ax)
                        res = mk(csg_pkg::SRC_A, ae, ax, csg_pkg::NRM_A_ENTRY, 1'b0,
                                 csg_pkg::NRM_A_EXIT, 1'b0);
                    else if (ae > bx)
                        res = mk(csg_pkg::SRC_B, be, bx, csg_pkg::NRM_B_ENTRY, 1'b0,
                                 csg_pkg::NRM_B_EXIT, 1'b0);
                    else if (ae < be)
                        res = mk(csg_pkg::SRC_A, ae, bx, csg_pkg::NRM_A_ENTRY, 1'b0,
                                 csg_pkg::NRM_B_EXIT, 1'b0);
                    else
                        res = mk(csg_pkg::SRC_B, be, ax, csg_pkg::NRM_B_ENTRY, 1'b0,
                                 csg_pkg::NRM_A_EXIT, 1'b0);
                end
                else if (ah)
                    res = mk(csg_pkg::SRC_A, ae, ax, csg_pkg::NRM_A_ENTRY, 1'b0,
                             csg_pkg::NRM_A_EXIT, 1'b0);
                else if (bh)
                    res = mk(csg_pkg::SRC_B, be, bx, csg_pkg::NRM_B_ENTRY, 1'b0,
                             csg_pkg::NRM_B_EXIT, 1'b0);
                res.occluded = (ah || bh) && ((ae < far_lim) || (be < far_lim));
            end
        endcase
    end

    assign result = res;

endmodule
